// ===== src/rational_arith_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on the rising clock, ignored while reset is held.
`define RAU_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("rational_arith_unit: assertion failed");
// Check a property on the rising clock, also during reset.
`define RAU_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rational_arith_unit: assertion failed");
`else
`define RAU_ASSERT(lbl, clk, rstn, prop)
`define RAU_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== src/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int WORD_BITS = 32;
    localparam int WIDE_BITS = 64;
    localparam int DIV_STEPS = WIDE_BITS;
    localparam int CNT_BITS  = $clog2(DIV_STEPS + 1);

    localparam logic [WIDE_BITS-1:0] LIM = {{(WIDE_BITS-1){1'b0}}, 1'b1} << (WORD_BITS - 1);

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GCD,
        S_GCD_W,
        S_QA,
        S_QA_W,
        S_QB,
        S_QB_W,
        S_MUL,
        S_NORM,
        S_QN,
        S_QN_W,
        S_QD,
        S_QD_W,
        S_CHECK
    } t_state;

endpackage

// ===== src/rau_div.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit divider
// Restoring unsigned divider, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module rau_div
    import rau_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WIDE_BITS-1:0] i_dividend,
    input  logic [WIDE_BITS-1:0] i_divisor,
    output logic                 o_done,
    output logic [WIDE_BITS-1:0] o_quot,
    output logic [WIDE_BITS-1:0] o_rem
);

    logic [CNT_BITS-1:0]  r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [WIDE_BITS-1:0] r_rem;
    logic [WIDE_BITS-1:0] r_quot;
    logic [WIDE_BITS-1:0] r_dvs;
    logic [WIDE_BITS:0]   w_trial;
    logic                 w_fit;

    assign w_trial = {r_rem, r_quot[WIDE_BITS-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift one dividend bit into the partial remainder per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= w_fit ? WIDE_BITS'(w_trial - {1'b0, r_dvs}) : w_trial[WIDE_BITS-1:0];
            r_quot <= {r_quot[WIDE_BITS-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== src/rational_arith_unit.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Add, subtract, multiply, divide or negate signed fractions, reduced by gcd.
// ----------------------------------------------------------------------------
// One request at a time: the unit drops s_axis_tready after taking a request
// and raises it again the cycle after the result is loaded into the output
// register. A loaded result may wait there for the receiver while the next
// request is worked on; a finished result waits in the check step until the
// output register is free. The work runs on one shared 64-bit restoring
// divider (each division is a start state followed by a wait state until
// done) and one 33x33 multiplier. Add and subtract with unequal denominators
// first run Euclid on the denominators and divide both by the gcd; every
// result with a nonzero numerator then runs Euclid on the numerator and
// denominator magnitudes and divides both by that gcd. A zero numerator
// skips reduction.
// Status: 0 ok, 1 zero denominator, 2 result out of 32-bit range (fields 0).
// Op codes above divide act as negate.
// ----------------------------------------------------------------------------
`include "rational_arith_unit_macros.svh"

module rational_arith_unit
    import rau_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // op[2:0], a_num[34:3], a_den[65:35], b_num[97:66], b_den[128:98], zero pad
    input  logic [135:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // res_num[31:0], res_den[62:32], status[64:63], zero pad
    output logic [71:0]  o_m_axis_tdata
);

    t_state r_state;
    t_state n_state;

    // request fields
    logic        [2:0]            r_op;
    logic signed [WORD_BITS-1:0]  r_an;
    logic signed [WORD_BITS-1:0]  r_bn;
    logic        [WORD_BITS-2:0]  r_ad;
    logic        [WORD_BITS-2:0]  r_bd;
    // denominators divided by their gcd
    logic        [WORD_BITS-2:0]  r_qa;
    logic        [WORD_BITS-2:0]  r_qb;
    // Euclid pair, reduction phase flag
    logic        [WIDE_BITS-1:0]  r_x;
    logic        [WIDE_BITS-1:0]  r_y;
    logic                         r_red;
    logic        [1:0]            r_mstep;
    logic signed [WIDE_BITS-1:0]  r_prod;
    logic signed [WIDE_BITS-1:0]  r_n;
    logic signed [WIDE_BITS-1:0]  r_d;
    logic                         r_neg;
    logic        [WIDE_BITS-1:0]  r_nm;
    logic        [WIDE_BITS-1:0]  r_dm;
    // result register
    logic                         r_ovalid;
    logic        [WORD_BITS-1:0]  r_res_num;
    logic        [WORD_BITS-2:0]  r_res_den;
    logic        [1:0]            r_status;

    logic                         w_accept;
    logic                         w_load;
    logic                         w_addsub;
    logic signed [WORD_BITS:0]    w_sb;
    logic signed [WORD_BITS:0]    w_ma;
    logic signed [WORD_BITS:0]    w_mb;
    logic signed [2*WORD_BITS+1:0] w_mp;
    logic                         w_div_start;
    logic        [WIDE_BITS-1:0]  w_div_n;
    logic        [WIDE_BITS-1:0]  w_div_d;
    logic                         w_div_done;
    logic        [WIDE_BITS-1:0]  w_quot;
    logic        [WIDE_BITS-1:0]  w_rem;
    logic        [WIDE_BITS-1:0]  w_nmag;
    logic        [WIDE_BITS-1:0]  w_dmag;
    logic                         w_ovf;

    rau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_n),
        .i_divisor  (w_div_d),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    // load the finished result once the output register is free or draining
    assign w_load   = (r_state == S_CHECK) && (!r_ovalid || i_m_axis_tready);
    assign w_addsub = (r_op == OP_ADD) || (r_op == OP_SUB);
    assign w_sb     = (r_op == OP_SUB) ? -(WORD_BITS+1)'(r_bn) : (WORD_BITS+1)'(r_bn);
    assign w_mp     = w_ma * w_mb;
    assign w_nmag   = r_n[WIDE_BITS-1] ? WIDE_BITS'(-r_n) : WIDE_BITS'(r_n);
    assign w_dmag   = r_d[WIDE_BITS-1] ? WIDE_BITS'(-r_d) : WIDE_BITS'(r_d);
    assign w_ovf    = (r_dm > LIM - 1'b1) || (r_neg ? (r_nm > LIM) : (r_nm > LIM - 1'b1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_MUL;
                    if (((i_s_axis_tdata[2:0] == OP_ADD) || (i_s_axis_tdata[2:0] == OP_SUB))
                        && (i_s_axis_tdata[65:35] != i_s_axis_tdata[128:98])) begin
                        n_state = S_GCD;
                    end
                end
            end
            S_GCD: begin
                if (r_y == '0) begin
                    n_state = r_red ? S_QN : S_QA;
                end else begin
                    n_state = S_GCD_W;
                end
            end
            S_GCD_W: if (w_div_done) begin
                n_state = S_GCD;
            end
            S_QA:    n_state = S_QA_W;
            S_QA_W:  if (w_div_done) begin
                n_state = S_QB;
            end
            S_QB:    n_state = S_QB_W;
            S_QB_W:  if (w_div_done) begin
                n_state = S_MUL;
            end
            S_MUL:   if (r_mstep == 2'd2) begin
                n_state = S_NORM;
            end
            S_NORM:  n_state = (w_nmag == '0) ? S_CHECK : S_GCD;
            S_QN:    n_state = S_QN_W;
            S_QN_W:  if (w_div_done) begin
                n_state = S_QD;
            end
            S_QD:    n_state = S_QD_W;
            S_QD_W:  if (w_div_done) begin
                n_state = S_CHECK;
            end
            S_CHECK: if (w_load) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs: handshake, divider launch, multiplier operands
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_div_start     = 1'b0;
        w_div_n         = r_x;
        w_div_d         = r_y;
        w_ma            = '0;
        w_mb            = '0;
        case (r_state)
            S_IDLE:  o_s_axis_tready = 1'b1;
            S_GCD:   w_div_start = (r_y != '0);
            S_QA: begin
                w_div_start = 1'b1;
                w_div_n     = WIDE_BITS'(r_ad);
                w_div_d     = r_x;
            end
            S_QB: begin
                w_div_start = 1'b1;
                w_div_n     = WIDE_BITS'(r_bd);
                w_div_d     = r_x;
            end
            S_QN: begin
                w_div_start = 1'b1;
                w_div_n     = r_nm;
                w_div_d     = r_x;
            end
            S_QD: begin
                w_div_start = 1'b1;
                w_div_n     = r_dm;
                w_div_d     = r_x;
            end
            S_MUL: begin
                // numerator = first + second product, denominator = third
                case (r_mstep)
                    2'd0: begin
                        w_ma = (WORD_BITS+1)'(r_an);
                        if (w_addsub) begin
                            w_mb = (WORD_BITS+1)'(r_qb);
                        end else if (r_op == OP_MUL) begin
                            w_mb = (WORD_BITS+1)'(r_bn);
                        end else if (r_op == OP_DIV) begin
                            w_mb = (WORD_BITS+1)'(r_bd);
                        end else begin
                            w_mb = -(WORD_BITS+1)'(1);
                        end
                    end
                    2'd1: begin
                        if (w_addsub) begin
                            w_ma = w_sb;
                            w_mb = (WORD_BITS+1)'(r_qa);
                        end
                    end
                    default: begin
                        if (w_addsub) begin
                            w_ma = (WORD_BITS+1)'(r_qa);
                            w_mb = (WORD_BITS+1)'(r_bd);
                        end else if (r_op == OP_MUL) begin
                            w_ma = (WORD_BITS+1)'(r_ad);
                            w_mb = (WORD_BITS+1)'(r_bd);
                        end else if (r_op == OP_DIV) begin
                            w_ma = (WORD_BITS+1)'(r_ad);
                            w_mb = (WORD_BITS+1)'(r_bn);
                        end else begin
                            w_ma = (WORD_BITS+1)'(r_ad);
                            w_mb = (WORD_BITS+1)'(1);
                        end
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_mstep  <= '0;
            r_red    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_mstep <= '0;
                r_red   <= 1'b0;
            end
            if (r_state == S_MUL) begin
                r_mstep <= r_mstep + 1'b1;
            end
            if (r_state == S_NORM) begin
                r_red <= 1'b1;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    // hold the request; equal denominators need no scaling
                    r_op <= i_s_axis_tdata[2:0];
                    r_an <= i_s_axis_tdata[34:3];
                    r_ad <= i_s_axis_tdata[65:35];
                    r_bn <= i_s_axis_tdata[97:66];
                    r_bd <= i_s_axis_tdata[128:98];
                    r_qa <= (WORD_BITS-1)'(1);
                    r_qb <= (WORD_BITS-1)'(1);
                    r_x  <= WIDE_BITS'(i_s_axis_tdata[65:35]);
                    r_y  <= WIDE_BITS'(i_s_axis_tdata[128:98]);
                end
            end
            S_GCD_W: begin
                if (w_div_done) begin
                    r_x <= r_y;
                    r_y <= w_rem;
                end
            end
            S_QA_W: if (w_div_done) begin
                r_qa <= w_quot[WORD_BITS-2:0];
            end
            S_QB_W: if (w_div_done) begin
                r_qb <= w_quot[WORD_BITS-2:0];
            end
            S_MUL: begin
                case (r_mstep)
                    2'd0: r_prod <= w_mp[WIDE_BITS-1:0];
                    2'd1: begin
                        r_n    <= r_prod;
                        r_prod <= w_mp[WIDE_BITS-1:0];
                    end
                    default: begin
                        r_n <= r_n + r_prod;
                        r_d <= w_mp[WIDE_BITS-1:0];
                    end
                endcase
            end
            S_NORM: begin
                r_nm  <= w_nmag;
                r_dm  <= w_dmag;
                r_neg <= (r_n[WIDE_BITS-1] != r_d[WIDE_BITS-1]) && (w_nmag != '0);
                r_x   <= w_nmag;
                r_y   <= w_dmag;
            end
            S_QN_W: if (w_div_done) begin
                r_nm <= w_quot;
            end
            S_QD_W: if (w_div_done) begin
                r_dm <= w_quot;
            end
            S_CHECK: begin
                // hold the result here until the output register frees up
                if (w_load) begin
                    if (r_dm == '0) begin
                        r_status  <= ST_ZDEN;
                        r_res_num <= r_neg ? WORD_BITS'(-r_nm) : WORD_BITS'(r_nm);
                        r_res_den <= '0;
                    end else if (w_ovf) begin
                        r_status  <= ST_OVF;
                        r_res_num <= '0;
                        r_res_den <= '0;
                    end else begin
                        r_status  <= ST_OK;
                        r_res_num <= r_neg ? WORD_BITS'(-r_nm) : WORD_BITS'(r_nm);
                        r_res_den <= r_dm[WORD_BITS-2:0];
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {7'd0, r_status, r_res_den, r_res_num};

    `RAU_ASSERT(a_hold_result, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
    `RAU_ASSERT(a_ok_den_nonzero, i_clk, i_rst_n, (o_m_axis_tvalid && r_status == ST_OK) |-> (r_res_den != '0))
    `RAU_ASSERT(a_ovf_zeroed, i_clk, i_rst_n, (o_m_axis_tvalid && r_status == ST_OVF) |-> (r_res_num == '0 && r_res_den == '0))
    `RAU_ASSERT(a_result_after_check, i_clk, i_rst_n, $rose(o_m_axis_tvalid) |-> $past(r_state == S_CHECK))

endmodule
